FILE: sv/pls_pkg.sv
`default_nettype none
package pls_pkg;

  localparam int CAPACITY = 64;
  localparam int ENTRY_W  = 16;

  // fixed field widths
  localparam int CMD_W = 3;
  localparam int POS_W = 7;
  localparam int VAL_W = 16;
  localparam int ST_W  = 2;
  localparam int CNT_W = $clog2(CAPACITY + 1);

  localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
  localparam logic [CMD_W-1:0] CMD_INS_AT   = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REM_HEAD = 3'd3;
  localparam logic [CMD_W-1:0] CMD_REM_TAIL = 3'd4;
  localparam logic [CMD_W-1:0] CMD_REM_AT   = 3'd5;

  localparam logic [ST_W-1:0] ST_OK     = 2'd0;
  localparam logic [ST_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL   = 2'd3;

  // shift command broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [POS_W-1:0]   pos;
    logic [ENTRY_W-1:0] value;
  } pls_op_t;

endpackage
`default_nettype wire

FILE: sv/pls_cell.sv
`default_nettype none
module pls_cell (
  input  wire                          clk,
  input  wire  [pls_pkg::POS_W-1:0]    cell_index,
  input  wire  pls_pkg::pls_op_t       op,
  input  wire  [pls_pkg::ENTRY_W-1:0]  left_val,
  input  wire  [pls_pkg::ENTRY_W-1:0]  right_val,
  output logic [pls_pkg::ENTRY_W-1:0]  val,
  output logic [pls_pkg::ENTRY_W-1:0]  tap
);
  import pls_pkg::*;

  logic [ENTRY_W-1:0] val_r;
  logic [ENTRY_W-1:0] val_nxt;

  always_comb begin
    val_nxt = val_r;
    if (op.ins) begin
      if (cell_index == op.pos) begin
        val_nxt = op.value;
      end else if (cell_index > op.pos) begin
        val_nxt = left_val;
      end
    end else if (op.rem) begin
      if (cell_index >= op.pos) begin
        val_nxt = right_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

  assign val = val_r;
  // contents seen before the shift when this cell is the one removed
  assign tap = (op.rem && (cell_index == op.pos)) ? val_r : '0;

endmodule
`default_nettype wire

FILE: sv/positional_list_store.sv
`default_nettype none
// Bounded ordered list of up to 64 entries, head at index 0. One request is
// taken per clock cycle (start while busy is low) and its result strobes on
// out_valid for one cycle via the execute and result registers; busy is set
// in reset and cleared at the first rising edge with rst_n high. The receiver
// cannot stall, so every result must be captured in its strobe cycle. Each
// entry lives in its own cell of a row; an insert shifts the cells behind the
// position one place toward the tail, a remove one place toward the head, all
// cells in parallel. Error requests report a status and leave the list as is.
module positional_list_store (
  input  wire                          clk,
  input  wire                          rst_n,
  input  wire                          start,
  output logic                         busy,
  input  wire  [pls_pkg::CMD_W-1:0]    in_command,
  input  wire  [pls_pkg::POS_W-1:0]    in_position,
  input  wire  [pls_pkg::VAL_W-1:0]    in_entry_value,
  output logic                         out_valid,
  output logic [pls_pkg::VAL_W-1:0]    out_removed_value,
  output logic [pls_pkg::ST_W-1:0]     out_status,
  output logic [pls_pkg::CNT_W-1:0]    out_entry_count
);
  import pls_pkg::*;

  logic busy_r;
  logic accept;

  // count is updated at accept so back to back requests check the right length
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  // decode of the incoming request
  logic [POS_W-1:0] dec_pos;
  logic [ST_W-1:0]  dec_status;
  logic             dec_ins;
  logic             dec_rem;
  logic [POS_W-1:0] count_pos;

  // execute stage: cells apply the shift in this cycle
  logic             ex_valid_r;
  pls_op_t          ex_op_r;
  logic [ST_W-1:0]  ex_status_r;
  logic [CNT_W-1:0] ex_count_r;

  // result registers
  logic             out_valid_r;
  logic [VAL_W-1:0] out_removed_r;
  logic [ST_W-1:0]  out_status_r;
  logic [CNT_W-1:0] out_count_r;

  logic [ENTRY_W-1:0] vals [CAPACITY];
  logic [ENTRY_W-1:0] taps [CAPACITY];
  logic [ENTRY_W-1:0] removed;

  assign accept    = start && !busy_r;
  assign count_pos = POS_W'(count_r);

  always_comb begin
    dec_pos    = '0;
    dec_status = ST_BADPOS;
    dec_ins    = 1'b0;
    dec_rem    = 1'b0;
    unique case (in_command)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        if (in_command == CMD_INS_HEAD) begin
          dec_pos = '0;
        end else if (in_command == CMD_INS_TAIL) begin
          dec_pos = count_pos;
        end else begin
          dec_pos = in_position;
        end
        // position check comes before the full check
        if (dec_pos > count_pos) begin
          dec_status = ST_BADPOS;
        end else if (count_r == CNT_W'(CAPACITY)) begin
          dec_status = ST_FULL;
        end else begin
          dec_status = ST_OK;
          dec_ins    = 1'b1;
        end
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT: begin
        if (in_command == CMD_REM_HEAD) begin
          dec_pos = '0;
        end else if (in_command == CMD_REM_TAIL) begin
          dec_pos = count_pos - POS_W'(1);
        end else begin
          dec_pos = in_position;
        end
        if (count_r == '0) begin
          dec_status = ST_EMPTY;
        end else if (dec_pos >= count_pos) begin
          dec_status = ST_BADPOS;
        end else begin
          dec_status = ST_OK;
          dec_rem    = 1'b1;
        end
      end
      default: begin
        // unused command codes do nothing
        dec_status = ST_BADPOS;
      end
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (accept) begin
      if (dec_ins) begin
        count_nxt = count_r + CNT_W'(1);
      end else if (dec_rem) begin
        count_nxt = count_r - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b1;
      count_r     <= '0;
      ex_valid_r  <= 1'b0;
      ex_op_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= 1'b0;
      count_r     <= count_nxt;
      ex_valid_r  <= accept;
      ex_op_r.ins <= accept && dec_ins;
      ex_op_r.rem <= accept && dec_rem;
      ex_op_r.pos <= dec_pos;
      ex_op_r.value <= ENTRY_W'(in_entry_value);
      out_valid_r <= ex_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    ex_status_r   <= dec_status;
    ex_count_r    <= count_nxt;
    out_removed_r <= VAL_W'(removed);
    out_status_r  <= ex_status_r;
    out_count_r   <= ex_count_r;
  end

  // row of cells, each neighbor fed from the adjacent cell
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [ENTRY_W-1:0] left_v;
    logic [ENTRY_W-1:0] right_v;
    if (i == 0) begin : g_head
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = vals[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = vals[i+1];
    end
    pls_cell u_cell (
      .clk        (clk),
      .cell_index (POS_W'(i)),
      .op         (ex_op_r),
      .left_val   (left_v),
      .right_val  (right_v),
      .val        (vals[i]),
      .tap        (taps[i])
    );
  end

  // at most one cell taps out a value, zero on anything but a good remove
  always_comb begin
    removed = '0;
    for (int k = 0; k < CAPACITY; k++) begin
      removed = removed | taps[k];
    end
  end

  assign busy              = busy_r;
  assign out_valid         = out_valid_r;
  assign out_removed_value = out_removed_r;
  assign out_status        = out_status_r;
  assign out_entry_count   = out_count_r;

endmodule
`default_nettype wire

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// list store bench: a shadow list held in a queue predicts every result,
// each strobed result is compared field by field with the oldest prediction
module testbench;
  import pls_pkg::*;

  // command codes the block does not define, both must report a bad position
  localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd6;
  localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd7;

  localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
  localparam int DRAIN_CYCLES = 8;       // idle margin after the last pending result
  localparam int MAX_REPORTS  = 10;

  // one result as the block reports it
  typedef struct packed {
    logic [VAL_W-1:0] removed;
    logic [ST_W-1:0]  status;
    logic [CNT_W-1:0] count;
  } list_result_t;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [CMD_W-1:0]  in_command;
  logic [POS_W-1:0]  in_position;
  logic [VAL_W-1:0]  in_entry_value;
  logic              out_valid;
  logic [VAL_W-1:0]  out_removed_value;
  logic [ST_W-1:0]   out_status;
  logic [CNT_W-1:0]  out_entry_count;

  // shadow copy of the list, head at index 0
  logic [ENTRY_W-1:0] list_shadow[$];
  // predicted results in request order
  list_result_t       pending_results[$];

  list_result_t want_result;
  int mismatches;
  int results_seen;
  int requests_sent;
  int peak_depth;
  int idle_pct;
  int status_hits[4];

  positional_list_store dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_position       (in_position),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_removed_value (out_removed_value),
    .out_status        (out_status),
    .out_entry_count   (out_entry_count)
  );

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog on total run length
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("timeout after %0d cycles, %0d results still pending", CYCLE_LIMIT,
             pending_results.size());
    $display("Verification failed");
    $finish;
  end

  // apply one request to the shadow list and return what the block should report
  function automatic list_result_t apply_list_command(input logic [CMD_W-1:0] cmd,
                                                      input logic [POS_W-1:0] pos,
                                                      input logic [VAL_W-1:0] val);
    list_result_t res;
    int depth;
    int idx;
    depth       = list_shadow.size();
    res.removed = '0;
    res.status  = ST_OK;
    case (cmd)
      CMD_INS_HEAD, CMD_INS_TAIL, CMD_INS_AT: begin
        idx = (cmd == CMD_INS_HEAD) ? 0 : (cmd == CMD_INS_TAIL) ? depth : int'(pos);
        // position check takes priority over the full check
        if (idx > depth) res.status = ST_BADPOS;
        else if (depth >= CAPACITY) res.status = ST_FULL;
        else list_shadow.insert(idx, val[ENTRY_W-1:0]);
      end
      CMD_REM_HEAD, CMD_REM_TAIL, CMD_REM_AT: begin
        idx = (cmd == CMD_REM_HEAD) ? 0 : (cmd == CMD_REM_TAIL) ? depth - 1 : int'(pos);
        // empty wins over any position problem
        if (depth == 0) res.status = ST_EMPTY;
        else if (idx >= depth) res.status = ST_BADPOS;
        else begin
          res.removed = VAL_W'(list_shadow[idx]);
          list_shadow.delete(idx);
        end
      end
      default: res.status = ST_BADPOS;
    endcase
    res.count = CNT_W'(list_shadow.size());
    return res;
  endfunction

  task automatic note_mismatch(input string what, input int want, input int got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch at %0t: %s expected 0x%0h got 0x%0h", $realtime, what, want, got);
  endtask

  // result checker: the block cannot be stalled, so every strobe is taken
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        note_mismatch("unexpected result, status", 0, out_status);
      end else begin
        want_result = pending_results.pop_front();
        if (out_removed_value !== want_result.removed)
          note_mismatch("removed value", want_result.removed, out_removed_value);
        if (out_status !== want_result.status)
          note_mismatch("status", want_result.status, out_status);
        if (out_entry_count !== want_result.count)
          note_mismatch("entry count", want_result.count, out_entry_count);
      end
    end
  end

  // send one request: each cycle idle with the phase's odds, drive at the
  // falling edge, then wait for the rising edge that takes it (start high, busy low)
  task automatic send_request(input logic [CMD_W-1:0] cmd, input logic [POS_W-1:0] pos,
                              input logic [VAL_W-1:0] val);
    list_result_t res;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start = 1'b0;
    end
    @(negedge clk);
    start          = 1'b1;
    in_command     = cmd;
    in_position    = pos;
    in_entry_value = val;
    @(posedge clk);
    while (busy) @(posedge clk);
    res = apply_list_command(cmd, pos, val);
    pending_results.push_back(res);
    status_hits[res.status]++;
    requests_sent++;
    if (list_shadow.size() > peak_depth) peak_depth = list_shadow.size();
  endtask

  // random value with the extremes showing up now and then
  function automatic logic [VAL_W-1:0] pick_value();
    int roll;
    roll = $urandom_range(19);
    if (roll == 0) return '0;
    if (roll == 1) return '1;
    return VAL_W'($urandom);
  endfunction

  // every operation plus the error paths on a short list
  task automatic test_directed_ops();
    idle_pct = 0;
    // removes on an empty list, including one with a wild position
    send_request(CMD_REM_HEAD, 7'd0, 16'hFFFF);
    send_request(CMD_REM_TAIL, 7'd0, 16'h0000);
    send_request(CMD_REM_AT, 7'd127, 16'h1234);
    // insert beyond the count on an empty list
    send_request(CMD_INS_AT, 7'd1, 16'hDEAD);
    // build a short list with every insert flavor
    send_request(CMD_INS_AT, 7'd0, 16'hFFFF);
    send_request(CMD_INS_HEAD, 7'd127, 16'h0000);
    send_request(CMD_INS_TAIL, 7'd127, 16'h8001);
    send_request(CMD_INS_AT, 7'd1, 16'h5AA5);
    send_request(CMD_INS_AT, 7'd4, 16'h7FFE);  // position equal to count is the tail
    // bad positions on a non-empty list
    send_request(CMD_INS_AT, 7'd6, 16'h1111);
    send_request(CMD_INS_AT, 7'd127, 16'h2222);
    send_request(CMD_REM_AT, 7'd5, 16'h3333);
    send_request(CMD_REM_AT, 7'd127, 16'h4444);
    // undefined commands leave the list alone
    send_request(CMD_SPARE_A, 7'd0, 16'h0000);
    send_request(CMD_SPARE_B, 7'd127, 16'hFFFF);
    // take it apart again from every end
    send_request(CMD_REM_AT, 7'd2, 16'hFFFF);
    send_request(CMD_REM_HEAD, 7'd0, 16'h0000);
    send_request(CMD_REM_TAIL, 7'd0, 16'h0000);
    send_request(CMD_REM_AT, 7'd1, 16'h0000);
    send_request(CMD_REM_AT, 7'd0, 16'h0000);
    send_request(CMD_REM_AT, 7'd0, 16'h0000);
  endtask

  // fill to capacity, hit the full and bad position paths, then drain
  task automatic test_full_list();
    int depth;
    int pick;
    idle_pct = 15;
    while (list_shadow.size() < CAPACITY) begin
      depth = list_shadow.size();
      pick  = $urandom_range(2);
      if (pick == 0) send_request(CMD_INS_HEAD, POS_W'($urandom), pick_value());
      else if (pick == 1) send_request(CMD_INS_TAIL, POS_W'($urandom), pick_value());
      else send_request(CMD_INS_AT, POS_W'($urandom_range(depth)), pick_value());
    end
    // full: every insert flavor is refused
    send_request(CMD_INS_HEAD, 7'd0, 16'hABCD);
    send_request(CMD_INS_TAIL, 7'd0, 16'hABCD);
    send_request(CMD_INS_AT, 7'd64, 16'hABCD);
    send_request(CMD_INS_AT, 7'd0, 16'hABCD);
    // beyond the count reports a bad position even when full
    send_request(CMD_INS_AT, 7'd65, 16'hABCD);
    send_request(CMD_REM_AT, 7'd64, 16'h0000);
    // last slot out and back in
    send_request(CMD_REM_AT, 7'd63, 16'h0000);
    send_request(CMD_INS_AT, 7'd63, 16'hFFFF);
    idle_pct = 83;
    while (list_shadow.size() > 0) begin
      depth = list_shadow.size();
      pick  = $urandom_range(2);
      if (pick == 0) send_request(CMD_REM_HEAD, POS_W'($urandom), pick_value());
      else if (pick == 1) send_request(CMD_REM_TAIL, POS_W'($urandom), pick_value());
      else send_request(CMD_REM_AT, POS_W'($urandom_range(depth - 1)), pick_value());
    end
    send_request(CMD_REM_TAIL, 7'd0, 16'h0000);
  endtask

  // random traffic: the list drifts up and down in stretches so that both the
  // near empty and near full ends see plenty of work
  task automatic test_random_mix(input int items, input int pct);
    int depth;
    int roll;
    int grow_pct;
    logic [CMD_W-1:0] cmd;
    logic [POS_W-1:0] pos;
    idle_pct = pct;
    grow_pct = 70;
    for (int n = 0; n < items; n++) begin
      if (n % 40 == 0) grow_pct = ($urandom_range(1) == 1) ? 75 : 30;
      depth = list_shadow.size();
      roll  = $urandom_range(99);
      if (roll < 3) begin
        cmd = ($urandom_range(1) == 1) ? CMD_SPARE_A : CMD_SPARE_B;
      end else if ($urandom_range(99) < grow_pct) begin
        roll = $urandom_range(2);
        cmd  = (roll == 0) ? CMD_INS_HEAD : (roll == 1) ? CMD_INS_TAIL : CMD_INS_AT;
      end else begin
        roll = $urandom_range(2);
        cmd  = (roll == 0) ? CMD_REM_HEAD : (roll == 1) ? CMD_REM_TAIL : CMD_REM_AT;
      end
      // mostly legal positions, sometimes anything the port can carry
      if ($urandom_range(99) < 12) pos = POS_W'($urandom);
      else if (cmd == CMD_REM_AT && depth > 0) pos = POS_W'($urandom_range(depth - 1));
      else pos = POS_W'($urandom_range(depth));
      send_request(cmd, pos, pick_value());
    end
  endtask

  initial begin
    // every input known from time zero
    rst_n          = 1'b0;
    start          = 1'b0;
    in_command     = '0;
    in_position    = '0;
    in_entry_value = '0;
    mismatches     = 0;
    results_seen   = 0;
    requests_sent  = 0;
    peak_depth     = 0;
    idle_pct       = 0;
    for (int s = 0; s < 4; s++) status_hits[s] = 0;

    // synchronous reset, released away from the rising edge
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed_ops();
    test_full_list();
    test_random_mix(170, 0);
    test_random_mix(170, 83);
    test_random_mix(150, 15);

    // stop sending, let the last results come out
    @(negedge clk);
    start = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("summary: %0d requests sent, %0d results checked, list depth peaked at %0d",
             requests_sent, results_seen, peak_depth);
    $display("status mix: ok %0d, bad position %0d, empty %0d, full %0d, mismatches %0d",
             status_hits[ST_OK], status_hits[ST_BADPOS], status_hits[ST_EMPTY],
             status_hits[ST_FULL], mismatches);
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
